@@ rtl/look_direction_from_mouse_unit_assert.svh @@
// Assertion macros for the look direction unit checker.
// Each macro expects a signal named clock in the scope of use; LDM_ASSERT also expects reset.
`ifndef LOOK_DIRECTION_FROM_MOUSE_UNIT_ASSERT_SVH
`define LOOK_DIRECTION_FROM_MOUSE_UNIT_ASSERT_SVH

// Check a property outside reset.
`define LDM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("look direction check failed");

// Check a property that also covers the reset cycles.
`define LDM_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("look direction reset check failed");

`endif

@@ rtl/ldm_pkg.sv @@
// Package for the look direction unit: field widths, register defaults,
// sequencer states and the sine table generator. No dependencies.
package ldm_pkg;

   // Default parameter values
   localparam int ANGLE_BITS_DEFAULT      = 24;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;

   // Field widths
   localparam int DELTA_BITS    = 16;
   localparam int SENS_BITS     = 16;
   localparam int LIMIT_BITS    = 22;
   localparam int CSR_DATA_BITS = 22;
   localparam int DIR_BITS      = 16;
   localparam int HEADING_BITS  = 24;
   localparam int ELEV_BITS     = 23;
   localparam int SINE_BITS     = 15;

   // Serial multiplier shape and product width
   localparam int MUL_DIGIT_BITS = 2;
   localparam int PROD_BITS      = DELTA_BITS + SENS_BITS;
   localparam int PSUM_BITS      = PROD_BITS + 2;

   // Q1.15 rounding
   localparam int Q15_SHIFT = 15;
   localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(16384);

   // Register defaults
   localparam logic [SENS_BITS-1:0]  SENS_RESET  = SENS_BITS'(4660);
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(4147655);

   // Register indexes
   typedef enum logic [0:0] {
      CSR_SENSITIVITY = 1'b0,
      CSR_PITCH_LIMIT = 1'b1
   } csr_index_type;

   // Sine lookup slots, in issue order
   localparam logic [2:0] LOOK_SIN_YAW   = 3'd0;
   localparam logic [2:0] LOOK_COS_YAW   = 3'd1;
   localparam logic [2:0] LOOK_SIN_PITCH = 3'd2;
   localparam logic [2:0] LOOK_COS_PITCH = 3'd3;
   localparam logic [2:0] LOOK_LAST      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_SUM,
      ST_CLAMP,
      ST_LOOKUP,
      ST_DIR,
      ST_OUT
   } ldm_state_type;

   // Quarter turn in Q61
   localparam logic [63:0] HALF_PI_Q61   = 64'h3243F6A8885A308D;
   localparam int          SERIES_TERMS  = 17;

   // Divide a series term by (2k)(2k+1); later terms are already zero
   function automatic logic [63:0] series_div(input logic [63:0] term, input int k);
      logic [63:0] res;
      case (k)
         1:       res = term / 64'd6;
         2:       res = term / 64'd20;
         3:       res = term / 64'd42;
         4:       res = term / 64'd72;
         5:       res = term / 64'd110;
         6:       res = term / 64'd156;
         7:       res = term / 64'd210;
         8:       res = term / 64'd272;
         9:       res = term / 64'd342;
         10:      res = term / 64'd420;
         11:      res = term / 64'd506;
         12:      res = term / 64'd600;
         13:      res = term / 64'd702;
         14:      res = term / 64'd812;
         15:      res = term / 64'd930;
         16:      res = term / 64'd1056;
         default: res = 64'd0;
      endcase
      return res;
   endfunction

   // Entry idx of the quarter-wave table, round(32767 * sin(idx*pi/2^(T+1))),
   // by a Taylor series in Q61; elaboration only
   function automatic logic [SINE_BITS-1:0] sine_entry(input int idx, input int tab_bits);
      logic [63:0]  n_mask;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  v;
      logic [127:0] wide;
      n_mask = (64'd1 << tab_bits) - 64'd1;
      x = (HALF_PI_Q61 >> tab_bits) * 64'(idx)
          + (((HALF_PI_Q61 & n_mask) * 64'(idx)) >> tab_bits);
      wide = 128'(x) * 128'(x);
      x2 = wide[124:61];
      term = x;
      sum = x;
      for (int k = 1; k < SERIES_TERMS; k++) begin
         if (term != 64'd0) begin
            wide = 128'(term) * 128'(x2);
            term = series_div(wide[124:61], k);
            if ((k & 1) != 0) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      wide = 128'(sum) * 128'd32767 + (128'd1 << 60);
      v = wide[124:61];
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[SINE_BITS-1:0];
   endfunction

endpackage

@@ rtl/ldm_req_if.sv @@
// Input channel of the look direction unit: mouse deltas.
// Depends on ldm_pkg for field widths.
interface ldm_req_if;
   import ldm_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DELTA_BITS-1:0] delta_x;
   logic signed [DELTA_BITS-1:0] delta_y;

   modport source (output valid, output delta_x, output delta_y, input ready);
   modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

@@ rtl/ldm_rsp_if.sv @@
// Result channel of the look direction unit: look vector and angles.
// Depends on ldm_pkg for field widths.
interface ldm_rsp_if;
   import ldm_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [DIR_BITS-1:0]  dir_x;
   logic signed [DIR_BITS-1:0]  dir_y;
   logic signed [DIR_BITS-1:0]  dir_z;
   logic [HEADING_BITS-1:0]     heading;
   logic signed [ELEV_BITS-1:0] elevation;

   modport source (output valid, output dir_x, output dir_y, output dir_z,
                   output heading, output elevation, input ready);
   modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                   input heading, input elevation, output ready);
endinterface

@@ rtl/ldm_sine_rom.sv @@
// Quarter-wave sine table with registered read, filled at elaboration.
// Depends on ldm_pkg for the entry generator.
module ldm_sine_rom #(
   parameter int TAB_BITS = ldm_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic [TAB_BITS:0]                  addr,
   output logic [ldm_pkg::SINE_BITS-1:0]      q
);
   import ldm_pkg::*;

   localparam int TAB_N = 1 << TAB_BITS;

   logic [SINE_BITS-1:0] tab_w [0:TAB_N];
   logic [SINE_BITS-1:0] q_ff;

   // Build the table entries as constants
   for (genvar g = 0; g <= TAB_N; g++) begin : g_tab
      localparam logic [SINE_BITS-1:0] ENTRY = sine_entry(g, TAB_BITS);
      assign tab_w[g] = ENTRY;
   end

   // Register the read beat
   always_ff @(posedge clock) begin
      q_ff <= tab_w[addr];
   end

   assign q = q_ff;
endmodule

@@ rtl/ldm_serial_mul.sv @@
// Digit-serial signed by unsigned multiplier, a few bits of b per cycle.
// Depends on ldm_pkg for default widths.
module ldm_serial_mul #(
   parameter int A_BITS     = ldm_pkg::DELTA_BITS,
   parameter int B_BITS     = ldm_pkg::SENS_BITS,
   parameter int DIGIT_BITS = ldm_pkg::MUL_DIGIT_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [A_BITS-1:0]         a,
   input  logic [B_BITS-1:0]                b,
   output logic                             done,
   output logic signed [A_BITS+B_BITS-1:0]  product
);
   import ldm_pkg::*;

   localparam int STEPS    = (B_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int LO_BITS  = STEPS * DIGIT_BITS;
   localparam int CNT_BITS = $clog2(STEPS + 1);

   logic signed [A_BITS-1:0]            a_ff;
   logic [LO_BITS-1:0]                  b_ff;
   logic [LO_BITS-1:0]                  b_in;
   logic signed [A_BITS:0]              hi_ff;
   logic signed [A_BITS:0]              hi_in;
   logic [LO_BITS-1:0]                  lo_ff;
   logic [LO_BITS-1:0]                  lo_in;
   logic [CNT_BITS-1:0]                 count_ff;
   logic [CNT_BITS-1:0]                 count_in;
   logic                                done_ff;
   logic                                done_in;
   logic [DIGIT_BITS-1:0]               digit_w;
   logic signed [A_BITS+DIGIT_BITS-1:0] part_w;
   logic signed [A_BITS+DIGIT_BITS:0]   sum_w;

   // One digit step: add a times the digit, shift the pair right by a digit
   always_comb begin
      digit_w = b_ff[DIGIT_BITS-1:0];
      part_w  = (A_BITS+DIGIT_BITS)'(a_ff) * (A_BITS+DIGIT_BITS)'($signed({1'b0, digit_w}));
      sum_w   = {{DIGIT_BITS{hi_ff[A_BITS]}}, hi_ff} + {part_w[A_BITS+DIGIT_BITS-1], part_w};
      hi_in   = sum_w[A_BITS+DIGIT_BITS:DIGIT_BITS];
      lo_in   = {sum_w[DIGIT_BITS-1:0], lo_ff[LO_BITS-1:DIGIT_BITS]};
      b_in    = b_ff >> DIGIT_BITS;
   end

   // Step count and completion pulse
   always_comb begin
      count_in = count_ff;
      if (start) begin
         count_in = CNT_BITS'(STEPS);
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_BITS'(1);
      end
      done_in = !start && (count_ff == CNT_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // Load operands on start, then advance one digit a cycle
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         b_ff  <= LO_BITS'(b);
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (count_ff != '0) begin
         b_ff  <= b_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign done    = done_ff;
   assign product = (A_BITS + B_BITS)'({hi_ff, lo_ff});
endmodule

@@ rtl/look_direction_from_mouse_unit.sv @@
// Look direction from mouse deltas: yaw and clamped pitch, Q1.15 look vector.
// One item at a time, paced by two 2-bit serial multipliers run twice (8 steps each)
// and four reads of the single-port sine table; a stalled result beat can hold up the
// next item. The result register frees the input side.
// Reset is synchronous: angles to zero, sensitivity and pitch limit to defaults.
// Uses ldm_pkg, ldm_req_if, ldm_rsp_if, ldm_sine_rom and ldm_serial_mul.
module look_direction_from_mouse_unit #(
   parameter int ANGLE_BITS      = ldm_pkg::ANGLE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = ldm_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   ldm_req_if.sink                             req,
   ldm_rsp_if.source                           rsp,
   input  logic                                csr_we,
   input  ldm_pkg::csr_index_type              csr_index,
   input  logic [ldm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import ldm_pkg::*;

   localparam int T = SINE_TABLE_BITS;
   localparam logic [T:0] TAB_N = (T + 1)'(1) << T;

   ldm_state_type state_ff;
   ldm_state_type state_in;
   logic [2:0]    cnt_ff;
   logic [2:0]    cnt_in;

   logic [SENS_BITS-1:0]  sens_ff;
   logic [LIMIT_BITS-1:0] limit_ff;

   logic [ANGLE_BITS-1:0]        yaw_ff;
   logic signed [ELEV_BITS-1:0]  pitch_ff;
   logic signed [PSUM_BITS-1:0]  psum_ff;
   logic signed [PSUM_BITS-1:0]  lim_w;
   logic signed [ELEV_BITS-1:0]  pitch_in;
   logic [ANGLE_BITS-1:0]        pa_w;

   logic signed [DIR_BITS-1:0] sy_ff;
   logic signed [DIR_BITS-1:0] cy_ff;
   logic signed [DIR_BITS-1:0] sp_ff;
   logic                       cp_neg_ff;

   logic [ANGLE_BITS-1:0] ang_w;
   logic [1:0]            quad_w;
   logic [T-1:0]          idx_w;
   logic [T:0]            rom_addr_w;
   logic [SINE_BITS-1:0]  rom_q_w;
   logic                  look_neg_ff;
   logic signed [DIR_BITS-1:0] rom_val_w;

   logic                        accept_w;
   logic                        mul_start_w;
   logic signed [DELTA_BITS-1:0] mul_ax_w;
   logic signed [DELTA_BITS-1:0] mul_ay_w;
   logic [SENS_BITS-1:0]        mul_b_w;
   logic                        done_x_w;
   logic                        done_y_w;
   logic signed [PROD_BITS-1:0] prod_x_w;
   logic signed [PROD_BITS-1:0] prod_y_w;
   logic signed [PROD_BITS-1:0] adj_x_w;
   logic signed [PROD_BITS-1:0] adj_z_w;
   logic                        load_out_w;

   logic                        rsp_valid_ff;
   logic signed [DIR_BITS-1:0]  dir_x_ff;
   logic signed [DIR_BITS-1:0]  dir_y_ff;
   logic signed [DIR_BITS-1:0]  dir_z_ff;
   logic [HEADING_BITS-1:0]     heading_ff;
   logic signed [ELEV_BITS-1:0] elev_ff;

   assign accept_w  = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff  <= SENS_RESET;
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SENSITIVITY: sens_ff  <= csr_wdata[SENS_BITS-1:0];
            CSR_PITCH_LIMIT: limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            default:         sens_ff  <= sens_ff;
         endcase
      end
   end

   // Sequencer: next state and control
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      mul_start_w = 1'b0;
      load_out_w  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept_w) begin
               mul_start_w = 1'b1;
               state_in    = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            if (done_x_w && done_y_w) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            cnt_in   = LOOK_SIN_YAW;
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == LOOK_LAST) begin
               mul_start_w = 1'b1;
               state_in    = ST_DIR;
            end
         end
         ST_DIR: begin
            if (done_x_w && done_y_w) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_out_w = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= LOOK_SIN_YAW;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Multiplier operands: deltas by sensitivity, then cosines and sines by |cos pitch|
   assign mul_ax_w = (state_ff == ST_IDLE) ? req.delta_x : cy_ff;
   assign mul_ay_w = (state_ff == ST_IDLE) ? req.delta_y : sy_ff;
   assign mul_b_w  = (state_ff == ST_IDLE) ? sens_ff : SENS_BITS'(rom_q_w);

   ldm_serial_mul #(
      .A_BITS     (DELTA_BITS),
      .B_BITS     (SENS_BITS),
      .DIGIT_BITS (MUL_DIGIT_BITS)
   ) u_mul_x (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_w),
      .a       (mul_ax_w),
      .b       (mul_b_w),
      .done    (done_x_w),
      .product (prod_x_w)
   );

   ldm_serial_mul #(
      .A_BITS     (DELTA_BITS),
      .B_BITS     (SENS_BITS),
      .DIGIT_BITS (MUL_DIGIT_BITS)
   ) u_mul_y (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_w),
      .a       (mul_ay_w),
      .b       (mul_b_w),
      .done    (done_y_w),
      .product (prod_y_w)
   );

   // Pitch clamp against the limit
   always_comb begin
      lim_w    = PSUM_BITS'(limit_ff);
      pitch_in = ELEV_BITS'(psum_ff);
      if (psum_ff > lim_w) begin
         pitch_in = ELEV_BITS'(lim_w);
      end else if (psum_ff < -lim_w) begin
         pitch_in = ELEV_BITS'(-lim_w);
      end
   end

   // Angle updates: yaw wraps, pitch sums exactly then clamps
   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff   <= '0;
         pitch_ff <= '0;
      end else if (state_ff == ST_SUM) begin
         yaw_ff <= yaw_ff + ANGLE_BITS'({{ANGLE_BITS{prod_x_w[PROD_BITS-1]}}, prod_x_w});
      end else if (state_ff == ST_CLAMP) begin
         pitch_ff <= pitch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         psum_ff <= PSUM_BITS'(pitch_ff) + PSUM_BITS'(prod_y_w);
      end
   end

   // Table address: yaw then pitch, sine then cosine (a quarter turn on)
   assign pa_w   = ANGLE_BITS'({{ANGLE_BITS{pitch_ff[ELEV_BITS-1]}}, pitch_ff});
   assign ang_w  = cnt_ff[1] ? pa_w : yaw_ff;
   assign quad_w = ang_w[ANGLE_BITS-1:ANGLE_BITS-2] + {1'b0, cnt_ff[0]};
   assign idx_w  = ang_w[ANGLE_BITS-3 -: T];
   assign rom_addr_w = quad_w[0] ? (TAB_N - {1'b0, idx_w}) : {1'b0, idx_w};

   ldm_sine_rom #(
      .TAB_BITS (T)
   ) u_sine_rom (
      .clock (clock),
      .addr  (rom_addr_w),
      .q     (rom_q_w)
   );

   // Track the sign of the beat in flight through the table
   always_ff @(posedge clock) begin
      look_neg_ff <= quad_w[1];
   end

   assign rom_val_w = look_neg_ff ? -DIR_BITS'(rom_q_w) : DIR_BITS'(rom_q_w);

   // Capture each table beat in the cycle after its address
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOKUP) begin
         case (cnt_ff - 3'd1)
            LOOK_SIN_YAW:   sy_ff     <= rom_val_w;
            LOOK_COS_YAW:   cy_ff     <= rom_val_w;
            LOOK_SIN_PITCH: sp_ff     <= rom_val_w;
            LOOK_COS_PITCH: cp_neg_ff <= look_neg_ff;
            default:        cp_neg_ff <= cp_neg_ff;
         endcase
      end
   end

   // Round the products, folding in the sign of cos pitch
   assign adj_x_w = cp_neg_ff ? (ROUND_HALF - prod_x_w) : (prod_x_w + ROUND_HALF);
   assign adj_z_w = cp_neg_ff ? (ROUND_HALF - prod_y_w) : (prod_y_w + ROUND_HALF);

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out_w) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out_w) begin
         dir_x_ff   <= adj_x_w[Q15_SHIFT+DIR_BITS-1:Q15_SHIFT];
         dir_y_ff   <= sp_ff;
         dir_z_ff   <= adj_z_w[Q15_SHIFT+DIR_BITS-1:Q15_SHIFT];
         heading_ff <= HEADING_BITS'({{HEADING_BITS{1'b0}}, yaw_ff});
         elev_ff    <= pitch_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.dir_x     = dir_x_ff;
   assign rsp.dir_y     = dir_y_ff;
   assign rsp.dir_z     = dir_z_ff;
   assign rsp.heading   = heading_ff;
   assign rsp.elevation = elev_ff;
endmodule

@@ rtl/ldm_checker.sv @@
// Port-level checks on the look direction unit, bound to the top level.
// Depends on ldm_pkg and look_direction_from_mouse_unit_assert.svh.
`include "look_direction_from_mouse_unit_assert.svh"

module ldm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [ldm_pkg::DIR_BITS-1:0]   dir_y,
   input logic [ldm_pkg::HEADING_BITS-1:0]      heading,
   input logic signed [ldm_pkg::ELEV_BITS-1:0]  elevation
);
   import ldm_pkg::*;

   // No result beat straight out of reset
   `LDM_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid)

   // One item at a time: input closes after a beat
   `LDM_ASSERT(a_accept_busy, (req_valid && req_ready) |=> !req_ready)

   // No result beat directly follows an accepted input when none was waiting
   `LDM_ASSERT(a_no_early_result, (req_valid && req_ready && !rsp_valid) |=> !rsp_valid)

   // Hold a stalled result beat
   `LDM_ASSERT(a_stall_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(heading) && $stable(elevation) && $stable(dir_y)))
endmodule

bind look_direction_from_mouse_unit ldm_checker u_ldm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .dir_y     (rsp.dir_y),
   .heading   (rsp.heading),
   .elevation (rsp.elevation)
);

@@ verif/look_direction_from_mouse_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for look_direction_from_mouse_unit: mouse delta beats in, look vector
// and angles out, each checked against an in-bench yaw/pitch and sine-table predictor or a typed row's expectation.
// Depends on ldm_pkg, ldm_req_if, ldm_rsp_if and the unit itself.
module look_direction_from_mouse_unit_tb;
   import ldm_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int TURN_BITS    = 24;
   localparam int TAB_BITS     = 10;
   localparam int TAB_STEPS    = 1 << TAB_BITS;
   localparam int MAX_IDLE     = 18;
   localparam int LONG_HOLD    = 300;
   localparam int SETTLE_TIME  = 40;
   localparam int REPORT_LIMIT = 100;
   localparam logic [63:0] QUARTER_TURN_Q61 = 64'h3243F6A8885A308D;

   typedef struct packed {
      logic signed [DIR_BITS-1:0]  dir_x;
      logic signed [DIR_BITS-1:0]  dir_y;
      logic signed [DIR_BITS-1:0]  dir_z;
      logic [HEADING_BITS-1:0]     heading;
      logic signed [ELEV_BITS-1:0] elevation;
   } look_type;

   typedef struct {
      logic signed [DELTA_BITS-1:0] dx;
      logic signed [DELTA_BITS-1:0] dy;
      bit                           typed;
      look_type                     want;
   } motion_row_type;

   // Looking straight ahead: yaw and pitch both zero
   localparam look_type AT_REST = '{16'sd32766, 16'sd0, 16'sd0, 24'd0, 23'sd0};
   localparam look_type NO_LOOK = '0;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   ldm_req_if req_ch ();
   ldm_rsp_if rsp_ch ();

   // Predictor state and register copies
   int                    sine_rom [0:TAB_STEPS];
   logic [TURN_BITS-1:0]  view_yaw;
   longint                view_pitch;
   logic [SENS_BITS-1:0]  step_per_count;
   logic [LIMIT_BITS-1:0] pitch_bound;

   look_type pending_looks [$];
   int       error_count;
   bit       pace_on;
   bit       long_hold_req;

   // Directed rows: typed ones come back to rest, the others go to the predictor
   motion_row_type motion_table [0:19] = '{
      '{16'sd0,      16'sd0,      1'b1, AT_REST},
      '{16'sd1,      16'sd1,      1'b0, NO_LOOK},
      '{-16'sd1,     -16'sd1,     1'b1, AT_REST},
      '{16'sd32767,  16'sd0,      1'b0, NO_LOOK},
      '{-16'sd32767, 16'sd0,      1'b1, AT_REST},
      '{-16'sd32768, 16'sd0,      1'b0, NO_LOOK},
      '{16'sd32767,  16'sd0,      1'b0, NO_LOOK},
      '{16'sd0,      16'sd32767,  1'b0, NO_LOOK},
      '{16'sd0,      16'sd32767,  1'b0, NO_LOOK},
      '{16'sd0,      -16'sd32768, 1'b0, NO_LOOK},
      '{16'sd0,      -16'sd1,     1'b0, NO_LOOK},
      '{16'sd0,      16'sd890,    1'b0, NO_LOOK},
      '{16'sd900,    16'sd0,      1'b0, NO_LOOK},
      '{16'sd900,    16'sd0,      1'b0, NO_LOOK},
      '{16'sd900,    16'sd0,      1'b0, NO_LOOK},
      '{16'sd900,    16'sd0,      1'b0, NO_LOOK},
      '{16'sd21845,  -16'sd21846, 1'b0, NO_LOOK},
      '{-16'sd21846, 16'sd21845,  1'b0, NO_LOOK},
      '{-16'sd1,     16'sd32767,  1'b0, NO_LOOK},
      '{16'sd0,      16'sd0,      1'b0, NO_LOOK}
   };

   look_direction_from_mouse_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Quarter-wave entry i: round(32767 * sin(i * pi / 2^(TAB_BITS+1))) by series in Q61
   function automatic int quarter_sine(input int unsigned i);
      logic [127:0] prod;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      logic [63:0]  v;
      int           k;
      x = (QUARTER_TURN_Q61 >> TAB_BITS) * 64'(i)
          + (((QUARTER_TURN_Q61 & 64'(TAB_STEPS - 1)) * 64'(i)) >> TAB_BITS);
      prod = 128'(x) * 128'(x);
      x2 = prod[124:61];
      term = x;
      sum = x;
      k = 1;
      while (k < 40 && term != 64'd0) begin
         prod = 128'(term) * 128'(x2);
         term = prod[124:61] / (64'(2 * k) * 64'(2 * k + 1));
         if (k % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
         k++;
      end
      prod = 128'(sum) * 128'd32767 + (128'd1 << 60);
      v = prod[124:61];
      return (v > 64'd32767) ? 32767 : int'(v);
   endfunction

   // Sine of a binary angle: quadrant from the top two bits, low bits dropped
   function automatic int angle_sine(input logic [TURN_BITS-1:0] a);
      logic [1:0]          quad;
      logic [TAB_BITS-1:0] idx;
      int                  v;
      quad = a[TURN_BITS-1 -: 2];
      idx = a[TURN_BITS-3 -: TAB_BITS];
      v = quad[0] ? sine_rom[TAB_STEPS - int'(idx)] : sine_rom[idx];
      return quad[1] ? -v : v;
   endfunction

   function automatic int angle_cosine(input logic [TURN_BITS-1:0] a);
      logic [TURN_BITS-1:0] shifted;
      shifted = a + (TURN_BITS'(1) << (TURN_BITS - 2));
      return angle_sine(shifted);
   endfunction

   // Q1.15 product, round half up with a floor shift
   function automatic int q15_product(input int a, input int b);
      longint p;
      p = longint'(a) * longint'(b) + 64'sd16384;
      return int'(p >>> 15);
   endfunction

   // Apply one mouse beat to the view angles and form the look vector
   function automatic look_type advance_look(input logic signed [DELTA_BITS-1:0] dx,
                                             input logic signed [DELTA_BITS-1:0] dy);
      longint               yaw_step;
      longint               p;
      longint               lim;
      logic [TURN_BITS-1:0] pa;
      int                   sy;
      int                   cy;
      int                   sp;
      int                   cp;
      look_type             r;
      yaw_step = longint'(dx) * longint'(step_per_count);
      view_yaw = view_yaw + yaw_step[TURN_BITS-1:0];
      lim = longint'(pitch_bound);
      p = view_pitch + longint'(dy) * longint'(step_per_count);
      if (p > lim) p = lim;
      if (p < -lim) p = -lim;
      view_pitch = p;
      pa = p[TURN_BITS-1:0];
      sy = angle_sine(view_yaw);
      cy = angle_cosine(view_yaw);
      sp = angle_sine(pa);
      cp = angle_cosine(pa);
      r.dir_x = DIR_BITS'(q15_product(cy, cp));
      r.dir_y = DIR_BITS'(sp);
      r.dir_z = DIR_BITS'(q15_product(sy, cp));
      r.heading = view_yaw;
      r.elevation = p[ELEV_BITS-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < REPORT_LIMIT) begin
         $display("[%0t] MISMATCH %s", $realtime, msg);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input longint got_v, input longint exp_v);
      if (got_v != exp_v) begin
         report_mismatch($sformatf("%s got %0d expected %0d", name, got_v, exp_v));
      end
   endtask

   // Offer one delta beat, after a random gap when pacing is on; predict once it is taken
   task automatic send_motion(input logic signed [DELTA_BITS-1:0] dx,
                              input logic signed [DELTA_BITS-1:0] dy,
                              input bit typed, input look_type want);
      int       gap;
      look_type calc;
      gap = pace_on ? $urandom_range(MAX_IDLE, 0) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.delta_x <= dx;
      req_ch.delta_y <= dy;
      do @(posedge clock); while (!req_ch.ready);
      calc = advance_look(dx, dy);
      pending_looks.push_back(typed ? want : calc);
   endtask

   // Drop valid and hold until every expected beat has come back
   task automatic drain_looks();
      req_ch.valid <= 1'b0;
      while (pending_looks.size() != 0) @(posedge clock);
   endtask

   // Write both registers back to back; upper data bits beyond a register are dropped
   task automatic set_view_regs(input logic [CSR_DATA_BITS-1:0] sens_data,
                                input logic [CSR_DATA_BITS-1:0] limit_data);
      csr_we    <= 1'b1;
      csr_index <= CSR_SENSITIVITY;
      csr_wdata <= sens_data;
      @(posedge clock);
      step_per_count = sens_data[SENS_BITS-1:0];
      csr_index <= CSR_PITCH_LIMIT;
      csr_wdata <= limit_data;
      @(posedge clock);
      pitch_bound = limit_data[LIMIT_BITS-1:0];
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [DELTA_BITS-1:0] extreme_delta();
      case ($urandom_range(4, 0))
         0:       return -16'sd32768;
         1:       return -16'sd1;
         2:       return 16'sd0;
         3:       return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   // Mix of full-range, small, extreme and pitch-walking deltas
   task automatic random_motion(input int count);
      logic signed [DELTA_BITS-1:0] dx;
      logic signed [DELTA_BITS-1:0] dy;
      repeat (count) begin
         case ($urandom_range(7, 0))
            0, 1, 2: begin
               dx = DELTA_BITS'($urandom);
               dy = DELTA_BITS'($urandom);
            end
            3, 4, 5: begin
               dx = DELTA_BITS'($urandom_range(128, 0) - 64);
               dy = DELTA_BITS'($urandom_range(128, 0) - 64);
            end
            6: begin
               dx = extreme_delta();
               dy = extreme_delta();
            end
            default: begin
               dx = DELTA_BITS'($urandom);
               dy = DELTA_BITS'($urandom_range(600, 0) - 300);
            end
         endcase
         send_motion(dx, dy, 1'b0, NO_LOOK);
      end
   endtask

   // Result side: random stall per beat when pacing is on, plus one long hold on request
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         stall = pace_on ? $urandom_range(MAX_IDLE, 0) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      look_type got;
      look_type exp_look;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.dir_x, rsp_ch.dir_y, rsp_ch.dir_z, rsp_ch.heading, rsp_ch.elevation};
         if (pending_looks.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected, heading %0d",
                                      got.heading));
         end else begin
            exp_look = pending_looks.pop_front();
            if (got !== exp_look) begin
               check_field("dir_x", got.dir_x, exp_look.dir_x);
               check_field("dir_y", got.dir_y, exp_look.dir_y);
               check_field("dir_z", got.dir_z, exp_look.dir_z);
               check_field("heading", got.heading, exp_look.heading);
               check_field("elevation", got.elevation, exp_look.elevation);
               if ($isunknown(got)) report_mismatch("unknown bits in result beat");
            end
         end
      end
   end

   // Main sequence
   initial begin
      for (int i = 0; i <= TAB_STEPS; i++) sine_rom[i] = quarter_sine(i);
      view_yaw       = '0;
      view_pitch     = 0;
      step_per_count = SENS_RESET;
      pitch_bound    = LIMIT_RESET;
      error_count    = 0;
      pace_on        = 1'b1;
      long_hold_req  = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.delta_x = '0;
      req_ch.delta_y = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_SENSITIVITY;
      csr_wdata      = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at reset settings
      foreach (motion_table[r]) begin
         send_motion(motion_table[r].dx, motion_table[r].dy, motion_table[r].typed,
                     motion_table[r].want);
      end
      drain_looks();

      // Keep offering beats while the result side holds off
      long_hold_req = 1'b1;
      random_motion(150);
      drain_looks();

      // Register settings, extremes first; pace off in every third phase
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: set_view_regs(22'd0, 22'h3FFFFF);
            1: set_view_regs(22'h3FFFFF, 22'd0);
            2: set_view_regs(22'h00FFFF, 22'h3FFFFF);
            3: set_view_regs(22'd1, 22'd1);
            4: set_view_regs(22'h00FFFF, 22'h3FFFFF);
            5: set_view_regs(22'h00FFFF, 22'd1000);
            9: set_view_regs(22'(SENS_RESET), 22'(LIMIT_RESET));
            default: set_view_regs(CSR_DATA_BITS'($urandom), CSR_DATA_BITS'($urandom));
         endcase
         pace_on = (ph % 3 != 2);
         random_motion(105);
         // Pin pitch at the top so the lowered limit bites on the next beat
         if (ph == 4) begin
            repeat (3) send_motion(16'sd0, 16'sd32767, 1'b0, NO_LOOK);
         end
         drain_looks();
      end

      repeat (SETTLE_TIME) @(posedge clock);
      if (pending_looks.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_looks.size()));
      end
      if (error_count == 0) begin
         $display("look_direction_from_mouse_unit test passed");
      end else begin
         $display("look_direction_from_mouse_unit test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("look_direction_from_mouse_unit test failed");
      $finish;
   end

endmodule
